[hw/rtl/pal_pkg.sv]
// package: shared constants, codes and types of the positional array list
`default_nettype none
package pal_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int ACT_W = 2;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W = 5;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
	} pal_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/pal_ctrl.sv]
// controller: item handshake state machine and result valid flag
`default_nettype none
module pal_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output pal_pkg::pal_cmd_t     cmd
);

	pal_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pal_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.load_in = 1'b0;
		cmd.exec = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			pal_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = pal_pkg::S_EXEC;
				end
			end
			pal_pkg::S_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					cmd.exec = 1'b1;
					state_d = pal_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pal_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[hw/rtl/pal_datapath.sv]
// datapath: held item, shifting entry cells, length count and result register
`default_nettype none
module pal_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pal_pkg::pal_cmd_t                   cmd,
	input  wire logic        [pal_pkg::ACT_W-1:0]    action,
	input  wire logic        [pal_pkg::POS_W-1:0]    position,
	input  wire logic signed [pal_pkg::VAL_W-1:0]    value,
	output logic             [pal_pkg::STAT_W-1:0]   status,
	output logic signed      [pal_pkg::VAL_W-1:0]    read_value,
	output logic             [pal_pkg::CNT_W-1:0]    count
);

	logic        [pal_pkg::ACT_W-1:0]  action_q;
	logic        [pal_pkg::POS_W-1:0]  position_q;
	logic signed [pal_pkg::VAL_W-1:0]  value_q;
	logic signed [pal_pkg::VAL_W-1:0]  cells_q [pal_pkg::CAPACITY];
	logic        [pal_pkg::CNT_W-1:0]  count_q;

	logic        [pal_pkg::STAT_W-1:0] status_q;
	logic signed [pal_pkg::VAL_W-1:0]  read_value_q;
	logic        [pal_pkg::CNT_W-1:0]  count_out_q;

	logic [pal_pkg::POS_W-1:0]  pos_m1;
	logic [pal_pkg::IDX_W-1:0]  pos_idx;
	logic                       pos_nz;
	logic                       in_list;
	logic                       in_list_ins;
	logic                       full;
	logic                       do_ins;
	logic                       do_del;
	logic                       do_rd;
	logic [pal_pkg::STAT_W-1:0] status_d;
	logic [pal_pkg::CNT_W-1:0]  count_d;

	always_comb begin
		pos_m1 = position_q - pal_pkg::POS_W'(1);
		pos_idx = pos_m1[pal_pkg::IDX_W-1:0];
		pos_nz = position_q != '0;
		in_list = pos_nz && ({1'b0, position_q} <= {1'b0, count_q});
		in_list_ins = pos_nz && ({1'b0, position_q} <= ({1'b0, count_q} + 6'd1));
		full = count_q == pal_pkg::CNT_W'(pal_pkg::CAPACITY);
		do_ins = 1'b0;
		do_del = 1'b0;
		do_rd = 1'b0;
		status_d = pal_pkg::STAT_RANGE;
		case (action_q)
			pal_pkg::ACT_INSERT: begin
				if (in_list_ins) begin
					if (full) begin
						status_d = pal_pkg::STAT_FULL;
					end else begin
						do_ins = 1'b1;
						status_d = pal_pkg::STAT_OK;
					end
				end
			end
			pal_pkg::ACT_DELETE: begin
				if (in_list) begin
					do_del = 1'b1;
					status_d = pal_pkg::STAT_OK;
				end
			end
			pal_pkg::ACT_READ: begin
				if (in_list) begin
					do_rd = 1'b1;
					status_d = pal_pkg::STAT_OK;
				end
			end
			default: begin
				status_d = pal_pkg::STAT_RANGE;
			end
		endcase
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + pal_pkg::CNT_W'(1);
		end else if (do_del) begin
			count_d = count_q - pal_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q <= action;
			position_q <= position;
			value_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int k = 0; k < pal_pkg::CAPACITY; k++) begin
				if (do_ins) begin
					if (pal_pkg::POS_W'(k) == pos_m1) begin
						cells_q[k] <= value_q;
					end else if (k > 0 && pal_pkg::POS_W'(k) > pos_m1) begin
						cells_q[k] <= cells_q[(k > 0) ? k - 1 : 0];
					end
				end else if (do_del) begin
					if (k < pal_pkg::CAPACITY - 1 && pal_pkg::POS_W'(k) >= pos_m1) begin
						cells_q[k] <= cells_q[(k < pal_pkg::CAPACITY - 1) ? k + 1 : k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			read_value_q <= do_rd ? cells_q[pos_idx] : '0;
			count_out_q <= count_d;
		end
	end

	assign status = status_q;
	assign read_value = read_value_q;
	assign count = count_out_q;

endmodule
`default_nettype wire

[hw/rtl/positional_array_list.sv]
// top level: ordered list of 16 signed words with positional insert, delete and read
//
// input channel in_valid/in_stall carries action, position (1-based) and value
// output channel out_valid/out_stall carries status, read_value and count
// an item is taken at a clock edge with valid high and stall low
// action: insert shifts later entries up, delete shifts them down, read looks one up
// bad positions and unused actions give out of range, insert into a full list gives full
// the list is never changed by a rejected item
// the result is registered when the held item executes, in the state after acceptance
// no new item is accepted before the held one executes, set by the accept then execute
// sequence of the controller; all entry cells shift in parallel in the execute cycle
// a finished result waits in the output register while the next item is accepted
// when the receiver stalls, execution of the held item waits until the result is taken
// reset empties the list and drops any pending result; entry cells are not cleared
`default_nettype none
module positional_array_list (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic        [pal_pkg::ACT_W-1:0]    action,
	input  wire logic        [pal_pkg::POS_W-1:0]    position,
	input  wire logic signed [pal_pkg::VAL_W-1:0]    value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic             [pal_pkg::STAT_W-1:0]   status,
	output logic signed      [pal_pkg::VAL_W-1:0]    read_value,
	output logic             [pal_pkg::CNT_W-1:0]    count
);

	pal_pkg::pal_cmd_t cmd;

	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	pal_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (action),
		.position   (position),
		.value      (value),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

endmodule
`default_nettype wire
